FILE: design/depq_pkg.sv
// Shared types, sizes and address helper for the double-ended priority queue.
`timescale 1ns / 1ps

package depq_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int OCNT_W   = 9;

    typedef enum logic [1:0] {
        OP_INSERT     = 2'd0,
        OP_REMOVE_MAX = 2'd1,
        OP_REMOVE_MIN = 2'd2,
        OP_CLEAR      = 2'd3
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] max_value;
        logic signed [DATA_W-1:0] min_value;
        logic                     is_empty;
        logic [OCNT_W-1:0]        element_count;
        logic                     insert_dropped;
    } out_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;        // capture the request
        logic scan_start;   // read the largest entry, index it
        logic scan_shift;   // move current entry up one, step down
        logic place_next;   // write new value above current entry
        logic place_first;  // write new value at the bottom
        logic pop_max;
        logic pop_min;
        logic clear;
        logic flag_drop;
        logic lookup;       // fetch both ends
        logic report;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_t  op;
        logic empty;
        logic full;
        logic greater;      // scanned entry above the new value
        logic last;         // scan index at the bottom entry
    } stat_t;

    // Circular buffer: logical offset from base, wrapped at CAPACITY
    function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] base,
                                                    input logic [ADDR_W-1:0] offset);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= (ADDR_W + 1)'(CAPACITY))
        begin
            sum = sum - (ADDR_W + 1)'(CAPACITY);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

FILE: design/depq_ctrl.sv
// Sequencing state machine for the double-ended priority queue.
`timescale 1ns / 1ps

module depq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  depq_pkg::stat_t stat,
    output depq_pkg::cmd_t  cmd,
    output logic            busy
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DISPATCH = 6'b000010,
        S_SCAN     = 6'b000100,
        S_PLACE    = 6'b001000,
        S_LOOKUP   = 6'b010000,
        S_REPORT   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_LOOKUP;
                case (stat.op)
                    depq_pkg::OP_INSERT:
                    begin
                        if (stat.full)
                        begin
                            cmd.flag_drop = 1'b1;
                        end
                        else if (stat.empty)
                        begin
                            cmd.place_first = 1'b1;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    depq_pkg::OP_REMOVE_MAX: cmd.pop_max = !stat.empty;
                    depq_pkg::OP_REMOVE_MIN: cmd.pop_min = !stat.empty;
                    depq_pkg::OP_CLEAR:      cmd.clear   = 1'b1;
                    default:                 cmd.clear   = 1'b1;
                endcase
            end
            S_SCAN:
            begin
                if (stat.greater)
                begin
                    cmd.scan_shift = 1'b1;
                    state_next     = stat.last ? S_PLACE : S_SCAN;
                end
                else
                begin
                    cmd.place_next = 1'b1;
                    state_next     = S_LOOKUP;
                end
            end
            S_PLACE:
            begin
                cmd.place_first = 1'b1;
                state_next      = S_LOOKUP;
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                cmd.report = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_report_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REPORT) |-> $past(state_reg == S_LOOKUP))
        else $error("report without lookup");

    a_accept_dispatches: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_DISPATCH))
        else $error("accepted request not dispatched");

    a_place_after_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PLACE) |-> $past(cmd.scan_shift && stat.last))
        else $error("bottom placement without full shift");

endmodule

FILE: design/depq_datapath.sv
// Circular ordered store, pointers and result assembly for the priority queue.
`timescale 1ns / 1ps

module depq_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  depq_pkg::in_t   request,
    input  depq_pkg::cmd_t  cmd,
    output depq_pkg::stat_t stat,
    output depq_pkg::out_t  result
);

    logic [depq_pkg::DATA_W-1:0] mem [depq_pkg::CAPACITY];

    depq_pkg::op_t                      op_reg;
    logic signed [depq_pkg::DATA_W-1:0] value_reg;
    logic [depq_pkg::ADDR_W-1:0]        head_reg;
    logic [depq_pkg::ADDR_W-1:0]        head_next;
    logic [depq_pkg::CNT_W-1:0]         count_reg;
    logic [depq_pkg::CNT_W-1:0]         count_next;
    logic [depq_pkg::ADDR_W-1:0]        idx_reg;
    logic [depq_pkg::ADDR_W-1:0]        idx_next;
    logic                               drop_reg;
    logic signed [depq_pkg::DATA_W-1:0] rd_a_reg;
    logic signed [depq_pkg::DATA_W-1:0] rd_b_reg;

    logic                        empty;
    logic [depq_pkg::ADDR_W-1:0] tail_idx;
    logic                        wr_en;
    logic [depq_pkg::ADDR_W-1:0] wr_addr;
    logic [depq_pkg::DATA_W-1:0] wr_data;
    logic                        rd_a_en;
    logic [depq_pkg::ADDR_W-1:0] rd_a_addr;
    logic                        rd_b_en;

    assign empty    = (count_reg == '0);
    assign tail_idx = depq_pkg::ADDR_W'(count_reg - depq_pkg::CNT_W'(1));

    assign stat.op      = op_reg;
    assign stat.empty   = empty;
    assign stat.full    = (count_reg == depq_pkg::CNT_W'(depq_pkg::CAPACITY));
    assign stat.greater = (rd_a_reg > value_reg);
    assign stat.last    = (idx_reg == '0);

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        wr_en      = 1'b0;
        wr_addr    = head_reg;
        wr_data    = value_reg;
        rd_a_en    = 1'b0;
        rd_a_addr  = depq_pkg::phys_addr(head_reg, tail_idx);
        rd_b_en    = 1'b0;

        if (cmd.scan_start)
        begin
            idx_next = tail_idx;
            rd_a_en  = 1'b1;
        end
        if (cmd.scan_shift)
        begin
            // entry above the new value moves up by one
            wr_en     = 1'b1;
            wr_addr   = depq_pkg::phys_addr(head_reg, idx_reg + 1'b1);
            wr_data   = rd_a_reg;
            idx_next  = idx_reg - 1'b1;
            rd_a_en   = (idx_reg != '0);
            rd_a_addr = depq_pkg::phys_addr(head_reg, idx_reg - 1'b1);
        end
        if (cmd.place_next)
        begin
            wr_en      = 1'b1;
            wr_addr    = depq_pkg::phys_addr(head_reg, idx_reg + 1'b1);
            count_next = count_reg + depq_pkg::CNT_W'(1);
        end
        if (cmd.place_first)
        begin
            wr_en      = 1'b1;
            count_next = count_reg + depq_pkg::CNT_W'(1);
        end
        if (cmd.pop_max)
        begin
            count_next = count_reg - depq_pkg::CNT_W'(1);
        end
        if (cmd.pop_min)
        begin
            head_next  = depq_pkg::phys_addr(head_reg, depq_pkg::ADDR_W'(1));
            count_next = count_reg - depq_pkg::CNT_W'(1);
        end
        if (cmd.clear)
        begin
            count_next = '0;
        end
        if (cmd.lookup)
        begin
            rd_a_en = !empty;
            rd_b_en = !empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_a_en)
        begin
            rd_a_reg <= mem[rd_a_addr];
        end
        if (rd_b_en)
        begin
            rd_b_reg <= mem[head_reg];
        end
        if (cmd.latch)
        begin
            op_reg    <= request.op;
            value_reg <= request.value;
        end
        idx_reg <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cmd.latch)
            begin
                drop_reg <= 1'b0;
            end
            else if (cmd.flag_drop)
            begin
                drop_reg <= 1'b1;
            end
        end
    end

    assign result.max_value      = empty ? '0 : rd_a_reg;
    assign result.min_value      = empty ? '0 : rd_b_reg;
    assign result.is_empty       = empty;
    assign result.element_count  = depq_pkg::OCNT_W'(count_reg);
    assign result.insert_dropped = drop_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= depq_pkg::CNT_W'(depq_pkg::CAPACITY))
        else $error("held count beyond capacity");

    a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.report && drop_reg) |-> (count_reg == depq_pkg::CNT_W'(depq_pkg::CAPACITY)))
        else $error("insert flagged dropped while store not full");

    a_place_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.place_next || cmd.place_first) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the store");

endmodule

FILE: design/double_ended_priority_queue_unit.sv
// Top level of the double-ended priority queue: controller plus datapath.
`timescale 1ns / 1ps

// Holds up to 256 signed 32-bit values in ascending order in a circular
// buffer (one write port, two read ports, registered read data).
// A request (op, value) is taken on a rising edge with start high and busy
// low. Ops: insert, remove largest, remove smallest, clear. A removal on an
// empty store changes nothing; an insert into a full store is dropped and
// flagged in insert_dropped.
// Each request yields exactly one result, shown on result for one cycle
// with done high: largest, smallest (both zero when empty), empty flag and
// count. The receiver cannot stall, so results are never held back.
// Each request passes through dispatch, lookup and report before the next
// can be accepted. An insert into an empty store is written at the bottom;
// an insert into a non-empty store first scans down from the largest value,
// shifting up one entry each held value greater than the new one; the single
// write port moves one entry per cycle during the shift.
// done rises in the report state, after the lookup of both ends.
// Reset clears the count and pointers; no clearing pass of the store
// is needed, so requests may start on the first cycle after reset.

module double_ended_priority_queue_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  depq_pkg::in_t  request,
    output logic           busy,
    output logic           done,
    output depq_pkg::out_t result
);

    depq_pkg::cmd_t  cmd;
    depq_pkg::stat_t stat;

    depq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    depq_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result)
    );

    assign done = cmd.report;

endmodule

FILE: dv/double_ended_priority_queue_unit_test.sv
// Self-checking testbench for the double-ended priority queue unit.
`timescale 1ns / 1ps

module double_ended_priority_queue_unit_test;

    localparam int PHASE_ITEMS   = 390;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = depq_pkg::CAPACITY + 40;

    localparam logic signed [depq_pkg::DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [depq_pkg::DATA_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

    typedef struct {
        depq_pkg::in_t  req;
        bit             typed;
        depq_pkg::out_t want;
    } directed_row_t;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    logic           done;
    depq_pkg::in_t  request;
    depq_pkg::out_t result;

    // ascending mirror of the store contents
    logic signed [depq_pkg::DATA_W-1:0] sorted_values[$];
    depq_pkg::out_t                     expected_reports[$];
    directed_row_t                      directed_rows[$];

    int gap_percent;
    int mismatches;
    int stall_cycles = 0;

    double_ended_priority_queue_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    always #2 clk = ~clk;

    function automatic depq_pkg::out_t apply_queue_op(depq_pkg::in_t req);
        depq_pkg::out_t rep;
        int             pos;
        rep = '0;
        case (req.op)
            depq_pkg::OP_INSERT:
            begin
                if (sorted_values.size() < depq_pkg::CAPACITY)
                begin
                    pos = sorted_values.size();
                    while (pos > 0 && sorted_values[pos-1] > req.value)
                    begin
                        pos--;
                    end
                    sorted_values.insert(pos, req.value);
                end
                else
                begin
                    rep.insert_dropped = 1'b1;
                end
            end
            depq_pkg::OP_REMOVE_MAX:
            begin
                if (sorted_values.size() > 0)
                begin
                    void'(sorted_values.pop_back());
                end
            end
            depq_pkg::OP_REMOVE_MIN:
            begin
                if (sorted_values.size() > 0)
                begin
                    void'(sorted_values.pop_front());
                end
            end
            default:
            begin
                sorted_values.delete();
            end
        endcase
        if (sorted_values.size() > 0)
        begin
            rep.max_value = sorted_values[$];
            rep.min_value = sorted_values[0];
        end
        else
        begin
            rep.is_empty = 1'b1;
        end
        rep.element_count = depq_pkg::OCNT_W'(sorted_values.size());
        return rep;
    endfunction

    function automatic void compare_field(string field, logic [depq_pkg::DATA_W-1:0] want,
                                          logic [depq_pkg::DATA_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %h, actual %h", $time, field, want, got);
        end
    endfunction

    function automatic void check_report(depq_pkg::out_t got);
        depq_pkg::out_t want;
        if (expected_reports.size() == 0)
        begin
            mismatches++;
            $display("%0t: result expected none, actual %h", $time, got);
            return;
        end
        want = expected_reports.pop_front();
        compare_field("max_value", want.max_value, got.max_value);
        compare_field("min_value", want.min_value, got.min_value);
        compare_field("is_empty", depq_pkg::DATA_W'(want.is_empty),
                      depq_pkg::DATA_W'(got.is_empty));
        compare_field("element_count", depq_pkg::DATA_W'(want.element_count),
                      depq_pkg::DATA_W'(got.element_count));
        compare_field("insert_dropped", depq_pkg::DATA_W'(want.insert_dropped),
                      depq_pkg::DATA_W'(got.insert_dropped));
    endfunction

    function automatic void add_row(depq_pkg::op_t op,
                                    logic signed [depq_pkg::DATA_W-1:0] value, bit typed,
                                    logic signed [depq_pkg::DATA_W-1:0] top,
                                    logic signed [depq_pkg::DATA_W-1:0] bottom, int count);
        directed_row_t r;
        r.req.op               = op;
        r.req.value            = value;
        r.typed                = typed;
        r.want                 = '0;
        r.want.max_value       = top;
        r.want.min_value       = bottom;
        r.want.is_empty        = (count == 0);
        r.want.element_count   = depq_pkg::OCNT_W'(count);
        directed_rows.push_back(r);
    endfunction

    function automatic logic signed [depq_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return MOST_NEG;
            1: return MOST_POS;
            2, 3, 4: return int'($urandom_range(0, 16)) - 8;  // duplicates
            default: return $urandom;
        endcase
    endfunction

    function automatic depq_pkg::op_t pick_op(int insert_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < insert_pct)
        begin
            return depq_pkg::OP_INSERT;
        end
        if (r == 99)
        begin
            return depq_pkg::OP_CLEAR;
        end
        return (r % 2) ? depq_pkg::OP_REMOVE_MAX : depq_pkg::OP_REMOVE_MIN;
    endfunction

    // Called at a rising edge; returns at the edge that takes the request.
    task automatic issue(depq_pkg::in_t req, bit typed, depq_pkg::out_t want);
        depq_pkg::out_t predicted;
        if ($urandom_range(0, 99) < gap_percent)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
        predicted = apply_queue_op(req);
        expected_reports.push_back(typed ? want : predicted);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_reports.size() != 0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            check_report(result);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("double_ended_priority_queue_unit_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        depq_pkg::in_t req;
        int            insert_pct;
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        gap_percent = 32;
        mismatches  = 0;
        insert_pct  = 50;

        // removals on empty, extremes, duplicates, clear with junk value
        add_row(depq_pkg::OP_REMOVE_MAX, 0, 1, 0, 0, 0);
        add_row(depq_pkg::OP_REMOVE_MIN, 32'hFFFF_FFFF, 1, 0, 0, 0);
        add_row(depq_pkg::OP_CLEAR, 32'h5A5A_5A5A, 1, 0, 0, 0);
        add_row(depq_pkg::OP_INSERT, MOST_NEG, 1, MOST_NEG, MOST_NEG, 1);
        add_row(depq_pkg::OP_INSERT, MOST_POS, 1, MOST_POS, MOST_NEG, 2);
        add_row(depq_pkg::OP_INSERT, 0, 1, MOST_POS, MOST_NEG, 3);
        add_row(depq_pkg::OP_INSERT, -1, 0, 0, 0, 0);
        add_row(depq_pkg::OP_INSERT, MOST_POS, 1, MOST_POS, MOST_NEG, 5);
        add_row(depq_pkg::OP_INSERT, MOST_NEG, 0, 0, 0, 0);
        add_row(depq_pkg::OP_REMOVE_MAX, 32'hFFFF_FFFF, 1, MOST_POS, MOST_NEG, 5);
        add_row(depq_pkg::OP_REMOVE_MAX, 0, 0, 0, 0, 0);
        add_row(depq_pkg::OP_REMOVE_MIN, 0, 0, 0, 0, 0);
        add_row(depq_pkg::OP_REMOVE_MIN, 32'hAAAA_AAAA, 0, 0, 0, 0);
        add_row(depq_pkg::OP_REMOVE_MIN, 0, 0, 0, 0, 0);
        add_row(depq_pkg::OP_REMOVE_MAX, 0, 1, 0, 0, 0);
        add_row(depq_pkg::OP_INSERT, 7, 0, 0, 0, 0);
        add_row(depq_pkg::OP_INSERT, 7, 0, 0, 0, 0);
        add_row(depq_pkg::OP_INSERT, -7, 0, 0, 0, 0);
        add_row(depq_pkg::OP_CLEAR, 32'hFFFF_FFFF, 1, 0, 0, 0);
        add_row(depq_pkg::OP_INSERT, 1, 0, 0, 0, 0);
        add_row(depq_pkg::OP_REMOVE_MIN, 32'hAAAA_AAAA, 0, 0, 0, 0);
        add_row(depq_pkg::OP_REMOVE_MAX, 0, 1, 0, 0, 0);
        add_row(depq_pkg::OP_INSERT, 32'h5555_5555, 0, 0, 0, 0);
        add_row(depq_pkg::OP_CLEAR, 0, 1, 0, 0, 0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        end
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            gap_percent = (phase == 0) ? 32 : (phase == 1) ? 81 : 0;
            if (phase == 0)
            begin
                // fill to capacity, then a few requests that must be dropped
                req.op = depq_pkg::OP_INSERT;
                while (sorted_values.size() < depq_pkg::CAPACITY)
                begin
                    req.value = pick_value();
                    issue(req, 1'b0, '0);
                end
                repeat (4)
                begin
                    req.value = pick_value();
                    issue(req, 1'b0, '0);
                end
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 48 == 0)
                begin
                    case ($urandom_range(0, 2))
                        0: insert_pct = 20;
                        1: insert_pct = 50;
                        default: insert_pct = 85;
                    endcase
                end
                if ($urandom_range(0, 99) == 0)
                begin
                    wait_drained();
                end
                req.op    = pick_op(insert_pct);
                req.value = pick_value();
                issue(req, 1'b0, '0);
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_reports.size() == 0)
        begin
            $display("double_ended_priority_queue_unit_test OK");
        end
        else
        begin
            $display("double_ended_priority_queue_unit_test NOT OK");
        end
        $finish;
    end

endmodule

FILE: files.f
design/depq_pkg.sv
design/depq_ctrl.sv
design/depq_datapath.sv
design/double_ended_priority_queue_unit.sv
dv/double_ended_priority_queue_unit_test.sv
